/* sv/tga_dec_pkg.sv */
`default_nettype none

package tga_dec_pkg;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_PIXEL  = 5'b00100,
    PH_PACKET = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_HEADER  = 2'd0;
  localparam logic [1:0] ERR_DEPTH   = 2'd1;
  localparam logic [1:0] ERR_SIZE    = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;
  localparam logic [1:0] ERR_NONE    = 2'd0;

  localparam logic [4:0] HDR_TYPE_IDX  = 5'd2;
  localparam logic [4:0] HDR_FIXED_LEN = 5'd12;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;

  localparam logic [7:0] TYPE_RAW     = 8'd2;
  localparam logic [7:0] TYPE_RLE     = 8'd10;
  localparam logic [7:0] DEPTH_24     = 8'd24;
  localparam logic [7:0] DEPTH_32     = 8'd32;
  localparam logic [7:0] PKT_RLE_FLAG = 8'd128;
  localparam logic [7:0] PKT_RLE_BIAS = 8'd127;

  localparam logic [1:0] LAST_IDX_24 = 2'd2;
  localparam logic [1:0] LAST_IDX_32 = 2'd3;

  localparam int TDATA_OUT_W = 80;
  localparam int TDATA_IN_W  = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* sv/tga_image_stream_decoder_unit.sv */
`default_nettype none

// Channel   Side    Payload
// s_axis    in      tdata: data_byte; tuser: first_byte
// m_axis    out     tdata: colour, run and header fields; tuser: kind; tlast: last
//
// One byte per cycle unless m_tready stalls; byte and result are each registered.
// Per-byte decode is one combinational step between the input and result registers.
// rst is synchronous and clears all control state; no clearing pass follows.
// A stall on m_tready holds the result register, then the input register.

module tga_image_stream_decoder_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [tga_dec_pkg::TDATA_IN_W-1:0]   s_tdata,   // [7:0] data_byte
  input  wire                                  s_tuser,   // [0] first_byte
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [tga_dec_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [7:0] red, [15:8] green,
                                                          // [23:16] blue, [31:24] alpha,
                                                          // [39:32] repeat_res,
                                                          // [55:40] image_width,
                                                          // [71:56] image_height,
                                                          // [72] has_alpha,
                                                          // [74:73] error_code, rest 0
  output logic [1:0]                           m_tuser,   // [1:0] kind
  output logic                                 m_tlast
);

  tga_dec_pkg::in_item_t in_item;
  tga_dec_pkg::in_item_t held_item;
  tga_dec_pkg::res_t     res;
  tga_dec_pkg::res_t     out_res;
  logic                  held_valid;
  logic                  advance;
  logic                  step;
  logic                  res_valid;

  assign in_item.data_byte  = s_tdata;
  assign in_item.first_byte = s_tuser;
  assign step               = held_valid && advance;

  tga_dec_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tga_dec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  tga_dec_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .advance   (advance)
  );

  assign m_tdata = {5'd0, out_res.error_code, out_res.has_alpha, out_res.image_height,
                    out_res.image_width, out_res.repeat_res, out_res.alpha,
                    out_res.blue, out_res.green, out_res.red};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tga_dec_pkg::KIND_ERROR |-> m_tlast)
    else $error("error result without last");

  a_header_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tga_dec_pkg::KIND_HEADER |-> !m_tlast && m_tdata[39:32] == 8'd0)
    else $error("header result marked last or carrying a run");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tga_dec_pkg::KIND_PIXEL |-> m_tdata[39:32] != 8'd0)
    else $error("pixel run with zero repeat");

  a_overrun_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tga_dec_pkg::KIND_PIXEL
      && m_tdata[74:73] == tga_dec_pkg::ERR_OVERRUN |-> m_tlast)
    else $error("clipped run not marked last");

endmodule

`default_nettype wire

/* sv/tga_dec_in_reg.sv */
`default_nettype none

module tga_dec_in_reg (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  tga_dec_pkg::in_item_t  in_item,
  input  wire                    advance,
  output logic                   held_valid,
  output tga_dec_pkg::in_item_t  held_item
);

  logic load;

  assign in_ready = !held_valid || advance;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* sv/tga_dec_core.sv */
`default_nettype none

module tga_dec_core (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    step,
  input  tga_dec_pkg::in_item_t  item,
  output logic                   res_valid,
  output tga_dec_pkg::res_t      res
);

  tga_dec_pkg::phase_t phase, phase_next;
  logic [4:0]  header_index, header_index_next;
  logic        is_compressed, is_compressed_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        four_bytes, four_bytes_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_raw, packet_is_raw_next;
  logic [1:0]  colour_index, colour_index_next;
  logic [23:0] colour_buffer, colour_buffer_next;

  always_comb begin
    tga_dec_pkg::phase_t ph;
    logic [4:0]  hidx;
    logic        comp;
    logic [15:0] wr;
    logic [15:0] hr;
    logic        fb;
    logic [31:0] pl;
    logic [7:0]  pk;
    logic        praw;
    logic [1:0]  ci;
    logic [7:0]  b;
    logic        err;
    logic [1:0]  err_code;
    logic [1:0]  last_idx;
    logic        over;

    b    = item.data_byte;
    ph   = phase;
    hidx = header_index;
    comp = is_compressed;
    wr   = width_reg;
    hr   = height_reg;
    fb   = four_bytes;
    pl   = pixels_left;
    pk   = packet_left;
    praw = packet_is_raw;
    ci   = colour_index;
    if (item.first_byte) begin
      ph   = tga_dec_pkg::PH_HEADER;
      hidx = '0;
      comp = 1'b0;
      wr   = '0;
      hr   = '0;
      fb   = 1'b0;
      pl   = '0;
      pk   = '0;
      praw = 1'b0;
      ci   = '0;
    end

    phase_next         = ph;
    header_index_next  = hidx;
    is_compressed_next = comp;
    width_reg_next     = wr;
    height_reg_next    = hr;
    four_bytes_next    = fb;
    pixels_left_next   = pl;
    packet_left_next   = pk;
    packet_is_raw_next = praw;
    colour_index_next  = ci;
    colour_buffer_next = colour_buffer;
    res                = '0;
    res_valid          = 1'b0;
    err                = 1'b0;
    err_code           = tga_dec_pkg::ERR_HEADER;
    last_idx           = fb ? tga_dec_pkg::LAST_IDX_32 : tga_dec_pkg::LAST_IDX_24;
    over               = 1'b0;

    case (ph)
      tga_dec_pkg::PH_HEADER: begin
        header_index_next = hidx + 5'd1;
        if (hidx < tga_dec_pkg::HDR_FIXED_LEN) begin
          if (hidx == tga_dec_pkg::HDR_TYPE_IDX) begin
            if (b == tga_dec_pkg::TYPE_RAW) begin
              is_compressed_next = 1'b0;
            end else if (b == tga_dec_pkg::TYPE_RLE) begin
              is_compressed_next = 1'b1;
            end else begin
              err = 1'b1;
            end
          end else if (b != 8'd0) begin
            err = 1'b1;
          end
        end else if (hidx == tga_dec_pkg::HDR_WIDTH_LO) begin
          width_reg_next = {wr[15:8], b};
        end else if (hidx == tga_dec_pkg::HDR_WIDTH_HI) begin
          width_reg_next = {b, wr[7:0]};
        end else if (hidx == tga_dec_pkg::HDR_HEIGHT_LO) begin
          height_reg_next = {hr[15:8], b};
        end else if (hidx == tga_dec_pkg::HDR_HEIGHT_HI) begin
          height_reg_next = {b, hr[7:0]};
        end else if (hidx == tga_dec_pkg::HDR_DEPTH) begin
          if (b != tga_dec_pkg::DEPTH_24 && b != tga_dec_pkg::DEPTH_32) begin
            err      = 1'b1;
            err_code = tga_dec_pkg::ERR_DEPTH;
          end else if (wr == 16'd0 || hr == 16'd0) begin
            err      = 1'b1;
            err_code = tga_dec_pkg::ERR_SIZE;
          end else begin
            four_bytes_next  = (b == tga_dec_pkg::DEPTH_32);
            pixels_left_next = wr * hr;
            res.kind         = tga_dec_pkg::KIND_HEADER;
            res.image_width  = wr;
            res.image_height = hr;
            res.has_alpha    = (b == tga_dec_pkg::DEPTH_32);
            res_valid        = 1'b1;
          end
        end else begin
          colour_index_next = '0;
          phase_next        = comp ? tga_dec_pkg::PH_PACKET : tga_dec_pkg::PH_PIXEL;
          header_index_next = '0;
        end
        if (err) begin
          header_index_next = hidx;
          phase_next        = tga_dec_pkg::PH_DONE;
          res.kind          = tga_dec_pkg::KIND_ERROR;
          res.error_code    = err_code;
          res.last          = 1'b1;
          res_valid         = 1'b1;
        end
      end
      tga_dec_pkg::PH_PACKET: begin
        if (b < tga_dec_pkg::PKT_RLE_FLAG) begin
          packet_is_raw_next = 1'b1;
          packet_left_next   = b + 8'd1;
        end else begin
          packet_is_raw_next = 1'b0;
          packet_left_next   = b - tga_dec_pkg::PKT_RLE_BIAS;
        end
        colour_index_next = '0;
        phase_next        = tga_dec_pkg::PH_PIXEL;
      end
      tga_dec_pkg::PH_PIXEL: begin
        if (ci != last_idx) begin
          colour_buffer_next[{ci, 3'b000} +: 8] = b;
          colour_index_next = ci + 2'd1;
        end else begin
          colour_index_next = '0;
          if (!comp || praw) begin
            res.repeat_res   = 8'd1;
            pixels_left_next = pl - 32'd1;
            if (comp) begin
              packet_left_next = pk - 8'd1;
              over = (pixels_left_next == 32'd0) && (packet_left_next != 8'd0);
            end
          end else begin
            if ({24'd0, pk} > pl) begin
              res.repeat_res   = pl[7:0];
              pixels_left_next = '0;
              over             = 1'b1;
            end else begin
              res.repeat_res   = pk;
              pixels_left_next = pl - {24'd0, pk};
            end
            packet_left_next = '0;
          end
          res.kind       = tga_dec_pkg::KIND_PIXEL;
          res.red        = fb ? colour_buffer[23:16] : b;
          res.green      = colour_buffer[15:8];
          res.blue       = colour_buffer[7:0];
          res.alpha      = fb ? b : 8'd0;
          res.error_code = over ? tga_dec_pkg::ERR_OVERRUN : tga_dec_pkg::ERR_NONE;
          res.last       = (pixels_left_next == 32'd0);
          res_valid      = 1'b1;
          if (pixels_left_next == 32'd0) begin
            phase_next = tga_dec_pkg::PH_DONE;
          end else if (comp && packet_left_next == 8'd0) begin
            phase_next = tga_dec_pkg::PH_PACKET;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tga_dec_pkg::PH_IDLE;
      header_index  <= '0;
      is_compressed <= 1'b0;
      width_reg     <= '0;
      height_reg    <= '0;
      four_bytes    <= 1'b0;
      pixels_left   <= '0;
      packet_left   <= '0;
      packet_is_raw <= 1'b0;
      colour_index  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      is_compressed <= is_compressed_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      four_bytes    <= four_bytes_next;
      pixels_left   <= pixels_left_next;
      packet_left   <= packet_left_next;
      packet_is_raw <= packet_is_raw_next;
      colour_index  <= colour_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      colour_buffer <= colour_buffer_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tga_dec_out_reg.sv */
`default_nettype none

module tga_dec_out_reg (
  input  wire                clk,
  input  wire                rst,
  input  wire                step,
  input  wire                res_valid,
  input  tga_dec_pkg::res_t  res,
  input  wire                out_ready,
  output logic               out_valid,
  output tga_dec_pkg::res_t  out_res,
  output logic               advance
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire
